// ===== rtl/core/yfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfd_pkg - shared types and constants of the yuv420 frame downscaler
// Holds field widths, register indexes, sequencer states and the status
// struct passed from the sequencer to the top level.
// ----------------------------------------------------------------------------
package yfd_pkg;

  localparam int unsigned SW_W      = 10;
  localparam int unsigned TW_W      = 11;
  localparam int unsigned ADDR_W    = 17;
  localparam int unsigned FRAC_BITS = 20;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned DIV_W     = 30;

  // frame store size in bytes, a power of two so reads wrap on the low bits
  localparam int unsigned FRAME_BYTES = 131072;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  localparam logic [1:0] MODE_NN   = 2'd0;
  localparam logic [1:0] MODE_HALF = 2'd1;
  localparam logic [1:0] MODE_QUAR = 2'd2;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RD,
    ST_ACC,
    ST_DONE,
    ST_DIVC,
    ST_DIVC_W,
    ST_DIVR,
    ST_DIVR_W,
    ST_NEXT,
    ST_OUT
  } seq_state_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic       busy;
    logic       res_valid;
    logic [1:0] res_plane;
    logic       res_fe;
  } seq_stat_t;

endpackage

// ===== rtl/core/yfd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfd_div - restoring divider, one quotient bit per cycle
// Computes floor(num / den) for the fixed point stride.
// ----------------------------------------------------------------------------
module yfd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [yfd_pkg::DIV_W-1:0]     num,
  input  logic [yfd_pkg::TW_W-1:0]      den,
  output logic                          done,
  output logic [yfd_pkg::DIV_W-1:0]     quo
);

  localparam int unsigned CNT_W = $clog2(yfd_pkg::DIV_W + 1);

  logic [yfd_pkg::DIV_W-1:0] q_r, q_nxt;
  logic [yfd_pkg::TW_W:0]    rem_r, rem_nxt;
  logic [yfd_pkg::TW_W-1:0]  den_r, den_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [yfd_pkg::TW_W+1:0]  trial;

  // one shift-subtract step per cycle
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[yfd_pkg::DIV_W-1]} - {2'b00, den_r};
    if (start) begin
      q_nxt   = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CNT_W'(yfd_pkg::DIV_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[yfd_pkg::TW_W+1]) begin
        rem_nxt = trial[yfd_pkg::TW_W:0];
        q_nxt   = {q_r[yfd_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[yfd_pkg::TW_W-1:0], q_r[yfd_pkg::DIV_W-1]};
        q_nxt   = {q_r[yfd_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== rtl/core/yfd_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfd_seq - emit sequencer
// Walks the fetch addresses of one destination byte over the single
// store port, accumulates, then advances the raster position using the
// shared divider for the fixed point strides.
// ----------------------------------------------------------------------------
module yfd_seq #(
  parameter int unsigned AW = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        restart,
  input  logic [yfd_pkg::SW_W-1:0]    src_w,
  input  logic [yfd_pkg::SW_W-1:0]    src_h,
  input  logic [yfd_pkg::TW_W-1:0     ] dst_w,
  input  logic [yfd_pkg::TW_W-1:0]    dst_h,
  output logic [AW-1:0]               rd_addr,
  output logic                        rd_en,
  input  logic [7:0]                  rd_data,
  output logic [7:0]                  res_pixel,
  output yfd_pkg::seq_stat_t          stat
);

  yfd_pkg::seq_state_t state_r, state_nxt;

  logic [1:0]              plane_r, plane_nxt;
  // the row count reaches the full target height before it wraps
  logic [yfd_pkg::TW_W-1:0] row_r, row_nxt;
  logic [yfd_pkg::SW_W-1:0] col_r, col_nxt;
  logic [yfd_pkg::POS_W-1:0] cpos_r, cpos_nxt, rpos_r, rpos_nxt;
  logic [3:0]              k_r, k_nxt;
  logic [11:0]             sum_r, sum_nxt;
  logic [7:0]              pix_r, pix_nxt;
  logic                    fe_r, fe_nxt;
  logic [1:0]              oplane_r, oplane_nxt;
  logic                    wrapc_r, wrapc_nxt;
  logic [AW+2:0]           base_r, base_nxt;
  logic [AW+2:0]           addr_r, addr_nxt;

  // clamped targets and plane geometry
  logic [yfd_pkg::TW_W-1:0] tw, th, dw, dh;
  logic [yfd_pkg::SW_W-1:0] sw, sh;
  logic [19:0]              area;
  logic [1:0]               mode;
  logic                     chroma_ok;
  logic [3:0]               nfetch;

  function automatic logic [yfd_pkg::TW_W-1:0] clampt(input logic [yfd_pkg::TW_W-1:0] v);
    if (v == '0) return yfd_pkg::TW_W'(1);
    if (v[yfd_pkg::TW_W-1] && v[yfd_pkg::TW_W-2:0] != '0) return yfd_pkg::TW_W'(1024);
    return v;
  endfunction

  always_comb begin
    tw   = clampt(dst_w);
    th   = clampt(dst_h);
    area = src_w * src_h;
    if (plane_r == yfd_pkg::PLANE_Y) begin
      sw = src_w; sh = src_h; dw = tw; dh = th;
    end else begin
      sw = src_w >> 1; sh = src_h >> 1; dw = tw >> 1; dh = th >> 1;
    end
    if ({tw, 1'b0} == {2'b00, src_w} && {th, 1'b0} == {2'b00, src_h})
      mode = yfd_pkg::MODE_HALF;
    else if ({tw, 2'b00} == {3'b000, src_w} && {th, 2'b00} == {3'b000, src_h})
      mode = yfd_pkg::MODE_QUAR;
    else
      mode = yfd_pkg::MODE_NN;
    chroma_ok = (tw >> 1) != '0 && (th >> 1) != '0;
    unique case (mode)
      yfd_pkg::MODE_HALF: nfetch = 4'd3;
      yfd_pkg::MODE_QUAR: nfetch = 4'd15;
      default:            nfetch = 4'd0;
    endcase
  end

  // shared divider for the strides
  logic                        div_start, div_done;
  logic [yfd_pkg::DIV_W-1:0]   div_num, div_quo;
  logic [yfd_pkg::TW_W-1:0]    div_den;

  yfd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // fetch address of sample k of the current byte
  logic [AW+2:0] off;
  always_comb begin
    unique case (mode)
      yfd_pkg::MODE_HALF:
        off = (AW+3)'({row_r, 1'b0} + k_r[1]) * sw + (AW+3)'({col_r, 1'b0} + k_r[0]);
      yfd_pkg::MODE_QUAR:
        off = (AW+3)'({row_r, 2'b00} + k_r[3:2]) * sw + (AW+3)'({col_r, 2'b00} + k_r[1:0]);
      default:
        off = (AW+3)'(rpos_r[31:20]) * sw + (AW+3)'(cpos_r[31:20]);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      yfd_pkg::ST_IDLE:   if (start) state_nxt = yfd_pkg::ST_SETUP;
      yfd_pkg::ST_SETUP:  state_nxt = yfd_pkg::ST_RD;
      yfd_pkg::ST_RD:     state_nxt = yfd_pkg::ST_ACC;
      yfd_pkg::ST_ACC:    state_nxt = (k_r == nfetch) ? yfd_pkg::ST_DONE : yfd_pkg::ST_RD;
      yfd_pkg::ST_DONE:   state_nxt = yfd_pkg::ST_DIVC;
      yfd_pkg::ST_DIVC:   state_nxt = yfd_pkg::ST_DIVC_W;
      yfd_pkg::ST_DIVC_W: if (div_done)
                            state_nxt = wrapc_r ? yfd_pkg::ST_DIVR : yfd_pkg::ST_NEXT;
      yfd_pkg::ST_DIVR:   state_nxt = yfd_pkg::ST_DIVR_W;
      yfd_pkg::ST_DIVR_W: if (div_done) state_nxt = yfd_pkg::ST_NEXT;
      yfd_pkg::ST_NEXT:   state_nxt = yfd_pkg::ST_OUT;
      yfd_pkg::ST_OUT:    state_nxt = yfd_pkg::ST_IDLE;
      default:            state_nxt = yfd_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    plane_nxt  = plane_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    cpos_nxt   = cpos_r;
    rpos_nxt   = rpos_r;
    k_nxt      = k_r;
    sum_nxt    = sum_r;
    pix_nxt    = pix_r;
    fe_nxt     = fe_r;
    oplane_nxt = oplane_r;
    wrapc_nxt  = wrapc_r;
    base_nxt   = base_r;
    addr_nxt   = addr_r;
    div_start  = 1'b0;
    div_num    = {sw, 20'b0};
    div_den    = dw;
    rd_en      = 1'b0;
    unique case (state_r)
      yfd_pkg::ST_IDLE: begin
        k_nxt   = '0;
        sum_nxt = '0;
      end
      yfd_pkg::ST_SETUP: begin
        unique case (plane_r)
          yfd_pkg::PLANE_Y: base_nxt = '0;
          yfd_pkg::PLANE_U: base_nxt = (AW+3)'(area);
          default:          base_nxt = (AW+3)'(area) + (AW+3)'(area >> 2);
        endcase
      end
      yfd_pkg::ST_RD: begin
        addr_nxt = base_r + off;
        rd_en    = 1'b1;
      end
      yfd_pkg::ST_ACC: begin
        sum_nxt = sum_r + 12'(rd_data);
        k_nxt   = k_r + 1'b1;
      end
      yfd_pkg::ST_DONE: begin
        unique case (mode)
          yfd_pkg::MODE_HALF: pix_nxt = sum_r[9:2];
          yfd_pkg::MODE_QUAR: pix_nxt = sum_r[11:4];
          default:            pix_nxt = sum_r[7:0];
        endcase
        oplane_nxt = plane_r;
        wrapc_nxt  = (yfd_pkg::TW_W'(col_r) + 1'b1) >= dw;
      end
      yfd_pkg::ST_DIVC: begin
        div_start = 1'b1;
      end
      yfd_pkg::ST_DIVC_W: begin
        if (div_done) begin
          if (wrapc_r) begin
            col_nxt  = '0;
            cpos_nxt = '0;
          end else begin
            col_nxt  = col_r + 1'b1;
            cpos_nxt = cpos_r + yfd_pkg::POS_W'(div_quo);
          end
        end
      end
      yfd_pkg::ST_DIVR: begin
        div_start = 1'b1;
        div_num   = {sh, 20'b0};
        div_den   = dh;
      end
      yfd_pkg::ST_DIVR_W: begin
        if (div_done) begin
          rpos_nxt = rpos_r + yfd_pkg::POS_W'(div_quo);
          row_nxt  = row_r + 1'b1;
        end
      end
      yfd_pkg::ST_NEXT: begin
        fe_nxt = 1'b0;
        if (wrapc_r && (row_r >= dh)) begin
          row_nxt  = '0;
          rpos_nxt = '0;
          if (plane_r == yfd_pkg::PLANE_Y && chroma_ok) plane_nxt = yfd_pkg::PLANE_U;
          else if (plane_r == yfd_pkg::PLANE_U) plane_nxt = yfd_pkg::PLANE_V;
          else begin
            plane_nxt = yfd_pkg::PLANE_Y;
            fe_nxt    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // the read address walks across the store modulo its size
  assign rd_addr = addr_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    sum_r    <= sum_nxt;
    pix_r    <= pix_nxt;
    oplane_r <= oplane_nxt;
    wrapc_r  <= wrapc_nxt;
    base_r   <= base_nxt;
    addr_r   <= addr_nxt;
    if (!rst_n || restart) begin
      state_r <= yfd_pkg::ST_IDLE;
      plane_r <= yfd_pkg::PLANE_Y;
      row_r   <= '0;
      col_r   <= '0;
      cpos_r  <= '0;
      rpos_r  <= '0;
      fe_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      plane_r <= plane_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      cpos_r  <= cpos_nxt;
      rpos_r  <= rpos_nxt;
      fe_r    <= fe_nxt;
    end
  end

  assign res_pixel       = pix_r;
  assign stat.busy       = state_r != yfd_pkg::ST_IDLE;
  assign stat.res_valid  = state_r == yfd_pkg::ST_OUT;
  assign stat.res_plane  = oplane_r;
  assign stat.res_fe     = fe_r;

endmodule

// ===== rtl/core/yuv420_frame_downscaler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_frame_downscaler_core - yuv420 box / nearest neighbour downscaler
// Timing: a load is written straight into the store; an emit runs its fetches
// (1 fetch nearest, 4 half, 16 quarter) over the single store read
// port and then the one-bit-per-cycle stride divider once or twice.
// Throughput: loads back to back while no result waits; after an emit the
// next item is accepted once its result leaves.
// Reset: synchronous active low; registers 320/240/320/240, store undefined.
// ----------------------------------------------------------------------------
module yuv420_frame_downscaler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // op
  input  logic [31:0] in_tdata,   // address[16:0], pixel[24:17], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_pixel[7:0]
  output logic [1:0]  out_tuser,  // plane[1:0]
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(yfd_pkg::FRAME_BYTES);

  logic [yfd_pkg::SW_W-1:0] src_w_r, src_h_r;
  logic [yfd_pkg::TW_W-1:0] dst_w_r, dst_h_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 10'd320;
      src_h_r <= 10'd240;
      dst_w_r <= 11'd320;
      dst_h_r <= 11'd240;
    end else if (cfg_we) begin
      unique case (cfg_index)
        yfd_pkg::REG_SRC_W: src_w_r <= cfg_wdata[9:0];
        yfd_pkg::REG_SRC_H: src_h_r <= cfg_wdata[9:0];
        yfd_pkg::REG_DST_W: dst_w_r <= cfg_wdata;
        default:            dst_h_r <= cfg_wdata;
      endcase
    end
  end

  // input decode
  logic            acc;
  logic [16:0]     ld_addr;
  assign ld_addr = in_tdata[16:0];
  assign acc     = in_tvalid && in_tready;

  yfd_pkg::seq_stat_t stat;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic [7:0]         rd_data_r;
  logic [7:0]         res_pixel;
  logic               out_full_r;

  // frame store, one port
  logic [7:0] mem [yfd_pkg::FRAME_BYTES];
  always_ff @(posedge clk) begin
    if (acc && !in_tuser && (32'(ld_addr) < 32'(yfd_pkg::FRAME_BYTES)))
      mem[ld_addr[AW-1:0]] <= in_tdata[24:17];
    else if (rd_en)
      rd_data_r <= mem[rd_addr];
  end

  yfd_seq #(.AW(AW)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (acc && in_tuser),
    .restart  (cfg_we),
    .src_w    (src_w_r),
    .src_h    (src_h_r),
    .dst_w    (dst_w_r),
    .dst_h    (dst_h_r),
    .rd_addr  (rd_addr),
    .rd_en    (rd_en),
    .rd_data  (rd_data_r),
    .res_pixel(res_pixel),
    .stat     (stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (stat.res_valid) begin
      out_tdata <= res_pixel;
      out_tuser <= stat.res_plane;
      out_tlast <= stat.res_fe;
    end
    if (!rst_n) out_full_r <= 1'b0;
    else if (stat.res_valid) out_full_r <= 1'b1;
    else if (out_tready) out_full_r <= 1'b0;
  end

  assign out_tvalid = out_full_r;
  assign in_tready  = !stat.busy && !out_full_r;

  // no ready while busy, a valid output plane, and an emit starts the sequencer
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_tready) else $error("ready while busy");
  a_res_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3) else $error("bad plane");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tuser && !cfg_we) |=> stat.busy) else $error("emit not started");

endmodule
